[design/ftso_pkg.sv]
package ftso_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned CfgWidth = 31;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REG_TIME_CONSTANT  = 2'd0,
    REG_VELOCITY_LIMIT = 2'd1,
    REG_ERROR_LIMIT    = 2'd2,
    REG_TIME_STEP      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_OP = 2'd0,
    SQRT_OP = 2'd1,
    DIV_OP = 2'd2
  } unit_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_SQ,
    S_CUBE,
    S_SQRT_CUBE,
    S_SQRT_AE,
    S_SUM,
    S_INV,
    S_NONLIN,
    S_RATIO,
    S_LIN,
    S_VEL,
    S_STEP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

[design/ftso_unit.sv]
module ftso_unit #(
  parameter int unsigned FRAC_BITS = ftso_pkg::FracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ftso_pkg::unit_ctl_t     ctl_i,
  input  logic signed [31:0]      a_i,
  input  logic signed [31:0]      b_i,
  output logic                    done_o,
  output logic signed [31:0]      res_o
);

  localparam int unsigned W = 64;
  localparam int unsigned CntW = 7;

  logic                  busy_q, busy_d;
  ftso_pkg::unit_op_e    op_q, op_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [W-1:0]          x_q, x_d;
  logic [W+1:0]          acc_q, acc_d;
  logic [W-1:0]          r_q, r_d;
  logic [W-1:0]          y_q, y_d;
  logic                  neg_q, neg_d;
  logic                  done_q, done_d;
  logic signed [31:0]    res_q, res_d;

  logic [W+1:0]          trial;
  logic [W+1:0]          rem_sh;
  logic [W-1:0]          mag_a, mag_b;
  logic signed [65:0]    prod_fin;
  logic [W-1:0]          shifted;
  logic                  rbits_nz;
  logic [W-1:0]          frac_mask;

  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    mag_a = a_i[31] ? W'(-{{32{a_i[31]}}, a_i}) : W'({32'd0, a_i});
    mag_b = b_i[31] ? W'(-{{32{b_i[31]}}, b_i}) : W'({32'd0, b_i});
    frac_mask = (W'(1) << FRAC_BITS) - W'(1);
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    acc_d  = acc_q;
    r_d    = r_q;
    y_d    = y_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;
    trial  = '0;
    rem_sh = '0;
    shifted = '0;
    rbits_nz = 1'b0;
    prod_fin = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctl_i.op;
      acc_d  = '0;
      r_d    = '0;
      case (ctl_i.op)
        ftso_pkg::MUL_OP: begin
          x_d   = mag_a;
          y_d   = mag_b;
          neg_d = a_i[31] ^ b_i[31];
          cnt_d = CntW'(32);
        end
        ftso_pkg::SQRT_OP: begin
          x_d   = {32'd0, a_i} << FRAC_BITS;
          y_d   = '0;
          neg_d = 1'b0;
          cnt_d = CntW'(32);
        end
        ftso_pkg::DIV_OP: begin
          x_d   = mag_a << FRAC_BITS;
          y_d   = mag_b;
          neg_d = a_i[31] ^ b_i[31];
          cnt_d = CntW'(64);
        end
        default: begin
          x_d   = '0;
          y_d   = '0;
          neg_d = 1'b0;
          cnt_d = CntW'(1);
        end
      endcase
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      case (op_q)
        ftso_pkg::MUL_OP: begin
          if (y_q[0]) begin
            acc_d = acc_q + {2'b00, x_q};
          end
          x_d = x_q << 1;
          y_d = y_q >> 1;
        end
        ftso_pkg::SQRT_OP: begin
          rem_sh = {acc_q[W-1:0], x_q[W-1:W-2]};
          trial  = {r_q[W-1:0], 2'b01};
          x_d    = x_q << 2;
          if (rem_sh >= trial) begin
            acc_d = rem_sh - trial;
            r_d   = {r_q[W-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            r_d   = {r_q[W-2:0], 1'b0};
          end
        end
        ftso_pkg::DIV_OP: begin
          rem_sh = {acc_q[W:0], x_q[W-1]};
          x_d    = x_q << 1;
          if (rem_sh >= {2'b00, y_q}) begin
            acc_d = rem_sh - {2'b00, y_q};
            r_d   = {r_q[W-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            r_d   = {r_q[W-2:0], 1'b0};
          end
        end
        default: begin
        end
      endcase
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        case (op_q)
          ftso_pkg::MUL_OP: begin
            shifted  = acc_d[W-1:0] >> FRAC_BITS;
            rbits_nz = |(acc_d[W-1:0] & frac_mask);
            if (neg_d) begin
              prod_fin = -($signed({2'b00, shifted}) + 66'(rbits_nz));
            end else begin
              prod_fin = $signed({2'b00, shifted});
            end
            res_d = ftso_pkg::sat32(prod_fin);
          end
          ftso_pkg::SQRT_OP: begin
            res_d = ftso_pkg::sat32($signed({2'b00, r_d}));
          end
          ftso_pkg::DIV_OP: begin
            if (neg_d) begin
              res_d = ftso_pkg::sat32(-$signed({2'b00, r_d}));
            end else begin
              res_d = ftso_pkg::sat32($signed({2'b00, r_d}));
            end
          end
          default: begin
            res_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ftso_pkg::MUL_OP;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    r_q   <= r_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

endmodule

[design/finite_time_state_observer_core.sv]
// Finite-time state observer, signed fixed point with FRAC_BITS fraction bits.
// Input channel: in_valid_i / in_stall_o carry measured_state_i and restart_i.
// Output channel: out_valid_o / out_stall_i carry velocity_estimate_o and
// state_estimate_o, one result transaction per input transaction.
// Configuration: cfg_we_i writes cfg_idx_i (0 time constant, 1 velocity limit,
// 2 error limit, 3 time step) with cfg_data_i; write only while idle.
// Multiplies, square roots and divides run on one shared bit-serial unit, one
// at a time; the error, sum and estimate additions are done in this module.
// One item takes 6 multiplies, 2 roots and 2 divides; a zero time constant
// skips one divide, and a zero error limit skips one divide and one multiply.
// The input is stalled while an item is in work and while a finished result
// waits; a stalled result holds its value until taken.
// Reset restores the register defaults (time constant and error limit 1.0,
// others 0) and clears both estimates. restart_i set clears the estimates
// before that sample is processed.
module finite_time_state_observer_core #(
  parameter int unsigned FRAC_BITS = ftso_pkg::FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] measured_state_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] velocity_estimate_o,
  output logic signed [31:0] state_estimate_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);

  localparam logic [30:0] One = 31'(1) << FRAC_BITS;

  ftso_pkg::state_e    st_q, st_d;
  logic [30:0]         tc_q, vl_q, el_q, ts_q;
  logic signed [31:0]  est_q, est_d;
  logic signed [31:0]  rate_q, rate_d;
  logic signed [31:0]  meas_q, meas_d;
  logic signed [31:0]  e_q, e_d;
  logic signed [31:0]  t1_q, t1_d;
  logic signed [31:0]  t2_q, t2_d;
  logic                ov_q, ov_d;
  logic                busy_q, busy_d;

  ftso_pkg::unit_ctl_t ctl;
  logic signed [31:0]  ua, ub;
  logic                udone;
  logic signed [31:0]  ures;

  logic signed [31:0]  ae;
  logic signed [31:0]  sgn;
  logic signed [31:0]  clampv;
  logic signed [32:0]  lim_s;

  ftso_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .a_i   (ua),
    .b_i   (ub),
    .done_o(udone),
    .res_o (ures)
  );

  assign in_stall_o          = busy_q || ov_q;
  assign out_valid_o         = ov_q;
  assign velocity_estimate_o = rate_q;
  assign state_estimate_o    = est_q;

  always_comb begin
    ae    = (e_q == 32'sh80000000) ? 32'sh7fffffff : (e_q[31] ? -e_q : e_q);
    sgn   = (e_q > 0) ? $signed({1'b0, One}) : ((e_q < 0) ? -$signed({1'b0, One}) : 32'sd0);
    lim_s = $signed({2'b00, el_q});
    if ($signed({e_q[31], e_q}) > lim_s) begin
      clampv = $signed({1'b0, el_q});
    end else if ($signed({e_q[31], e_q}) < -lim_s) begin
      clampv = -$signed({1'b0, el_q});
    end else begin
      clampv = e_q;
    end
  end

  always_comb begin
    st_d   = st_q;
    est_d  = est_q;
    rate_d = rate_q;
    meas_d = meas_q;
    e_d    = e_q;
    t1_d   = t1_q;
    t2_d   = t2_q;
    ov_d   = ov_q;
    busy_d = busy_q;
    ctl    = '{start: 1'b0, op: ftso_pkg::MUL_OP};
    ua     = '0;
    ub     = '0;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    case (st_q)
      ftso_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          meas_d = measured_state_i;
          busy_d = 1'b1;
          if (restart_i) begin
            est_d  = '0;
            rate_d = '0;
          end
          st_d = ftso_pkg::S_ERR;
        end
      end
      ftso_pkg::S_ERR: begin
        e_d  = ftso_pkg::sat32(66'(meas_q) - 66'(est_q));
        st_d = ftso_pkg::S_SQ;
      end
      ftso_pkg::S_SQ: begin
        ctl  = '{start: 1'b1, op: ftso_pkg::MUL_OP};
        ua   = e_q;
        ub   = e_q;
        st_d = ftso_pkg::S_CUBE;
      end
      ftso_pkg::S_CUBE: begin
        if (udone) begin
          ctl  = '{start: 1'b1, op: ftso_pkg::MUL_OP};
          ua   = ae;
          ub   = ures;
          st_d = ftso_pkg::S_SQRT_CUBE;
        end
      end
      ftso_pkg::S_SQRT_CUBE: begin
        if (udone) begin
          ctl  = '{start: 1'b1, op: ftso_pkg::SQRT_OP};
          ua   = (ures > 0) ? ures : 32'sd0;
          st_d = ftso_pkg::S_SQRT_AE;
        end
      end
      ftso_pkg::S_SQRT_AE: begin
        if (udone) begin
          t1_d = ures;
          ctl  = '{start: 1'b1, op: ftso_pkg::SQRT_OP};
          ua   = ae;
          st_d = ftso_pkg::S_SUM;
        end
      end
      ftso_pkg::S_SUM: begin
        if (udone) begin
          t1_d = ftso_pkg::sat32(66'(t1_q) + 66'(ures));
          st_d = ftso_pkg::S_INV;
        end
      end
      ftso_pkg::S_INV: begin
        if (tc_q == '0) begin
          t2_d = 32'sh7fffffff;
          st_d = ftso_pkg::S_NONLIN;
        end else begin
          ctl  = '{start: 1'b1, op: ftso_pkg::DIV_OP};
          ua   = $signed({1'b0, One});
          ub   = $signed({1'b0, tc_q});
          st_d = ftso_pkg::S_NONLIN;
        end
      end
      ftso_pkg::S_NONLIN: begin
        if (tc_q == '0 || udone) begin
          ctl  = '{start: 1'b1, op: ftso_pkg::MUL_OP};
          ua   = (tc_q == '0) ? t2_q : ures;
          ub   = t1_q;
          st_d = ftso_pkg::S_RATIO;
        end
      end
      ftso_pkg::S_RATIO: begin
        if (udone) begin
          t1_d = ures;
          ctl  = '{start: 1'b1, op: ftso_pkg::MUL_OP};
          ua   = ures;
          ub   = sgn;
          st_d = ftso_pkg::S_LIN;
        end
      end
      ftso_pkg::S_LIN: begin
        if (udone) begin
          t1_d = ures;
          if (el_q == '0) begin
            t2_d = '0;
            st_d = ftso_pkg::S_STEP;
          end else begin
            ctl  = '{start: 1'b1, op: ftso_pkg::DIV_OP};
            ua   = clampv;
            ub   = $signed({1'b0, el_q});
            st_d = ftso_pkg::S_VEL;
          end
        end
      end
      ftso_pkg::S_VEL: begin
        if (udone) begin
          ctl  = '{start: 1'b1, op: ftso_pkg::MUL_OP};
          ua   = $signed({1'b0, vl_q});
          ub   = ures;
          st_d = ftso_pkg::S_STEP;
        end
      end
      ftso_pkg::S_STEP: begin
        if (el_q == '0 || udone) begin
          rate_d = ftso_pkg::sat32(66'(t1_q) + ((el_q == '0) ? 66'sd0 : 66'(ures)));
          ctl    = '{start: 1'b1, op: ftso_pkg::MUL_OP};
          ua     = $signed({1'b0, ts_q});
          ub     = rate_d;
          st_d   = ftso_pkg::S_OUT;
        end
      end
      ftso_pkg::S_OUT: begin
        if (udone) begin
          est_d  = ftso_pkg::sat32(66'(est_q) + 66'(ures));
          ov_d   = 1'b1;
          busy_d = 1'b0;
          st_d   = ftso_pkg::S_IDLE;
        end
      end
      default: begin
        st_d = ftso_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ftso_pkg::S_IDLE;
      est_q  <= '0;
      rate_q <= '0;
      ov_q   <= 1'b0;
      busy_q <= 1'b0;
      tc_q   <= One;
      vl_q   <= '0;
      el_q   <= One;
      ts_q   <= '0;
    end else begin
      st_q   <= st_d;
      est_q  <= est_d;
      rate_q <= rate_d;
      ov_q   <= ov_d;
      busy_q <= busy_d;
      if (cfg_we_i) begin
        case (ftso_pkg::reg_idx_e'(cfg_idx_i))
          ftso_pkg::REG_TIME_CONSTANT:  tc_q <= cfg_data_i;
          ftso_pkg::REG_VELOCITY_LIMIT: vl_q <= cfg_data_i;
          ftso_pkg::REG_ERROR_LIMIT:    el_q <= cfg_data_i;
          ftso_pkg::REG_TIME_STEP:      ts_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q <= meas_d;
    e_q    <= e_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
  end

endmodule

[dv/finite_time_state_observer_core_tb.sv]
module finite_time_state_observer_core_tb;

  localparam int unsigned FRAC = ftso_pkg::FracBits;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic signed [31:0] vel;
    logic signed [31:0] est;
  } estimate_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] measured_state_i = '0;
  logic               restart_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] velocity_estimate_o;
  logic signed [31:0] state_estimate_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = ftso_pkg::REG_TIME_CONSTANT;
  logic [30:0]        cfg_data_i = '0;

  estimate_t  expected_estimates[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  longint     cycle_count = 0;

  logic [30:0]        obs_time_constant;
  logic [30:0]        obs_velocity_limit;
  logic [30:0]        obs_error_limit;
  logic [30:0]        obs_time_step;
  logic signed [31:0] obs_estimate;
  logic signed [31:0] obs_rate;

  finite_time_state_observer_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .measured_state_i, .restart_i,
    .out_valid_o, .out_stall_i, .velocity_estimate_o, .state_estimate_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> FRAC);
  endfunction

  function automatic logic signed [31:0] fx_root(input logic signed [31:0] a);
    longint unsigned x;
    longint unsigned res;
    longint unsigned bitv;
    if (a <= 0) return '0;
    x = longint'(a) << FRAC;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return clip32(longint'(res));
  endfunction

  function automatic estimate_t observe(input logic signed [31:0] meas, input logic rst_est);
    logic signed [31:0] one, e, ae, cube, sum, inv, sgn, nonlin, lin, v;
    longint             lim, c;
    estimate_t          r;
    one = 32'sd1 << FRAC;
    if (rst_est) begin
      obs_estimate = '0;
      obs_rate = '0;
    end
    e = clip32(longint'(meas) - longint'(obs_estimate));
    ae = clip32(e < 0 ? -longint'(e) : longint'(e));
    cube = fx_mul(ae, fx_mul(e, e));
    sum = clip32(longint'(fx_root(cube)) + longint'(fx_root(ae)));
    if (obs_time_constant == 0) inv = 32'sh7fffffff;
    else inv = clip32((64'sd1 << (2 * FRAC)) / longint'({1'b0, obs_time_constant}));
    sgn = (e > 0) ? one : ((e < 0) ? -one : '0);
    nonlin = fx_mul(fx_mul(inv, sum), sgn);
    if (obs_error_limit == 0) begin
      lin = '0;
    end else begin
      lim = longint'({1'b0, obs_error_limit});
      c = longint'(e);
      if (c > lim) c = lim;
      if (c < -lim) c = -lim;
      lin = fx_mul($signed({1'b0, obs_velocity_limit}), clip32((c * longint'(one)) / lim));
    end
    v = clip32(longint'(nonlin) + longint'(lin));
    obs_rate = v;
    obs_estimate = clip32(longint'(obs_estimate)
                          + longint'(fx_mul($signed({1'b0, obs_time_step}), v)));
    r.vel = obs_rate;
    r.est = obs_estimate;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %s (cycle %0d)", msg, cycle_count);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    estimate_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected result transaction");
      end else begin
        want = expected_estimates.pop_front();
        if (velocity_estimate_o !== want.vel)
          report_mismatch($sformatf("velocity_estimate: got %0d expected %0d",
                                    velocity_estimate_o, want.vel));
        if (state_estimate_o !== want.est)
          report_mismatch($sformatf("state_estimate: got %0d expected %0d",
                                    state_estimate_o, want.est));
      end
    end
  end

  task automatic write_reg(input ftso_pkg::reg_idx_e idx, input logic [30:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ftso_pkg::REG_TIME_CONSTANT:  obs_time_constant = value;
      ftso_pkg::REG_VELOCITY_LIMIT: obs_velocity_limit = value;
      ftso_pkg::REG_ERROR_LIMIT:    obs_error_limit = value;
      default:                      obs_time_step = value;
    endcase
  endtask

  task automatic configure(input logic [30:0] t, input logic [30:0] vl,
                           input logic [30:0] el, input logic [30:0] ts);
    write_reg(ftso_pkg::REG_TIME_CONSTANT, t);
    write_reg(ftso_pkg::REG_VELOCITY_LIMIT, vl);
    write_reg(ftso_pkg::REG_ERROR_LIMIT, el);
    write_reg(ftso_pkg::REG_TIME_STEP, ts);
  endtask

  task automatic send_sample(input logic signed [31:0] meas, input logic rst_est);
    in_valid_i <= 1'b1;
    measured_state_i <= meas;
    restart_i <= rst_est;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_estimates.push_back(observe(meas, rst_est));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_estimates.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_reset_state;
    send_sample(32'sh0123_4567, 1'b0);
    drain();
  endtask

  task automatic test_directed;
    configure(31'h0100_0000, 31'h0080_0000, 31'h0100_0000, 31'h0004_0000);
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    send_sample(32'sd0, 1'b1);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sh0100_0000, 1'b0);
    send_sample(-32'sh0100_0000, 1'b0);
    drain();
    // zero time constant, zero error limit
    configure(31'd0, 31'h7fffffff, 31'd0, 31'h0000_1000);
    send_sample(32'sh0200_0000, 1'b1);
    send_sample(-32'sh0300_0000, 1'b0);
    send_sample(32'sh7fffffff, 1'b0);
    drain();
    configure(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_sample(32'sh7fffffff, 1'b1);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh4000_0000, 1'b0);
    drain();
    configure(31'd1, 31'h7fffffff, 31'd1, 31'h0001_0000);
    send_sample(32'sd3, 1'b1);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'sh80000000, 1'b1);
    drain();
  endtask

  function automatic logic [30:0] pick_reg();
    case ($urandom_range(5))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom);
      default: return 31'($urandom_range(32'h0400_0000, 1));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'($urandom);
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return obs_estimate + $signed(32'($urandom_range(64)) - 32'sd32);
      default: return obs_estimate + $signed(32'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
    endcase
  endfunction

  task automatic test_random(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        drain();
        configure(pick_reg(), pick_reg(), pick_reg(),
                  $urandom_range(3) == 0 ? pick_reg() : 31'($urandom_range(32'h0100_0000)));
      end
      send_sample(pick_sample(), $urandom_range(19) == 0);
    end
    drain();
  endtask

  initial begin
    obs_time_constant = 31'h0100_0000;
    obs_velocity_limit = '0;
    obs_error_limit = 31'h0100_0000;
    obs_time_step = '0;
    obs_estimate = '0;
    obs_rate = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random(0, 0, 420);
    test_random(85, 0, 420);
    test_random(0, 85, 420);
    test_random(19, 19, 420);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[finite_time_state_observer_core.f]
design/ftso_pkg.sv
design/ftso_unit.sv
design/finite_time_state_observer_core.sv
dv/finite_time_state_observer_core_tb.sv
